>>> design/utpd_pkg.sv
`default_nettype none

package utpd_pkg;

    localparam int VALUE_W      = 64;
    localparam int DIGIT_DEPTH  = 20;
    localparam int BCD_W        = DIGIT_DEPTH * 4;
    localparam int DIGIT_IDX_W  = $clog2(DIGIT_DEPTH);
    localparam int DCOUNT_W     = $clog2(DIGIT_DEPTH + 1);
    // value bits folded into the BCD word per conversion cycle
    localparam int STEP_BITS    = 4;
    localparam int CONV_STEPS   = VALUE_W / STEP_BITS;
    localparam int STEP_CNT_W   = $clog2(CONV_STEPS);

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_FILL   = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Double dabble: STEP_BITS rounds of add-3 correction and shift-in, MSB first.
    function automatic logic [BCD_W-1:0] dabble_step(
        input logic [BCD_W-1:0]     bcd,
        input logic [STEP_BITS-1:0] bits
    );
        logic [BCD_W-1:0] acc;
        acc = bcd;
        for (int s = STEP_BITS - 1; s >= 0; s--)
        begin
            for (int d = 0; d < DIGIT_DEPTH; d++)
            begin
                if (acc[d*4 +: 4] >= 4'd5)
                begin
                    acc[d*4 +: 4] = acc[d*4 +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[s]};
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

>>> design/unsigned_to_padded_decimal.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// -------   ---------  ------------------  -------------------------------
// in        sink       in_valid/in_stall   value[63:0]
// out       source     out_valid/out_stall char_code[7:0], last
// cfg       sink       cfg_valid/cfg_ready cfg_index[1:0], cfg_data[5:0]
//
// One number runs through the conversion (double dabble, 4 bits per cycle
// through the shared add-3/shift unit), digit count and sizing, then the
// characters are emitted, each loaded into the output register when it is
// empty or being taken; the next number can be taken once the last is loaded.
// in_stall is high from acceptance until the last character
// is loaded into the output register. out_stall only pauses emission; the
// output register lets the next number enter while the last character waits.
// rst_n clears state, registers and the output valid asynchronously.

module unsigned_to_padded_decimal #(
    parameter int MAX_WIDTH = 32
) (
    input  wire                              clk,
    input  wire                              rst_n,
    // input items
    input  wire                              in_valid,
    output logic                             in_stall,
    input  wire  [utpd_pkg::VALUE_W-1:0]     value,
    // result items
    output logic                             out_valid,
    input  wire                              out_stall,
    output logic [7:0]                       char_code,
    output logic                             last,
    // configuration writes
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [utpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [utpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import utpd_pkg::*;

    // character counts run up to MAX_WIDTH
    localparam int CNT_W = $clog2(MAX_WIDTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_COUNT,
        ST_SIZE,
        ST_EMIT
    } state_t;

    // configuration registers
    logic [CFG_DATA_W-1:0] field_width_reg;
    logic [CFG_DATA_W-1:0] min_digits_reg;
    logic                  zero_fill_reg;

    state_t                state_reg,       state_next;
    logic [VALUE_W-1:0]    value_reg,       value_next;
    logic [BCD_W-1:0]      bcd_reg,         bcd_next;
    logic [STEP_CNT_W-1:0] step_reg,        step_next;
    logic [DCOUNT_W-1:0]   digit_count_reg, digit_count_next;
    logic [CNT_W-1:0]      body_reg,        body_next;
    logic [CNT_W-1:0]      emit_pos_reg,    emit_pos_next;
    logic                  out_valid_reg,   out_valid_next;
    logic [7:0]            char_code_reg,   char_code_next;
    logic                  last_reg,        last_next;

    logic [CNT_W-1:0]      width_cap;
    logic [CNT_W-1:0]      prec_cap;
    logic [CNT_W-1:0]      digits_ext;
    logic [CNT_W-1:0]      body_calc;
    logic [DCOUNT_W-1:0]   digit_count_calc;
    logic                  load_ok;
    logic [3:0]            cur_digit;
    logic [7:0]            cur_char;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign char_code = char_code_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg <= '0;
            min_digits_reg  <= '0;
            zero_fill_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FIELD_WIDTH: field_width_reg <= cfg_data;
                CFG_MIN_DIGITS:  min_digits_reg  <= cfg_data;
                CFG_ZERO_FILL:   zero_fill_reg   <= cfg_data[0];
                default:         ; // unknown index: write dropped
            endcase
        end
    end

    // widths above MAX_WIDTH clip to it
    always_comb
    begin
        if (int'(field_width_reg) > MAX_WIDTH)
            width_cap = CNT_W'(MAX_WIDTH);
        else
            width_cap = CNT_W'(field_width_reg);
        if (int'(min_digits_reg) > MAX_WIDTH)
            prec_cap = CNT_W'(MAX_WIDTH);
        else
            prec_cap = CNT_W'(min_digits_reg);
    end

    // highest nonzero digit sets the count; zero still shows one digit
    always_comb
    begin
        digit_count_calc = DCOUNT_W'(1);
        for (int d = 0; d < DIGIT_DEPTH; d++)
        begin
            if (bcd_reg[d*4 +: 4] != 4'd0)
                digit_count_calc = DCOUNT_W'(d + 1);
        end
    end

    assign digits_ext = CNT_W'(digit_count_reg);
    assign body_calc  = (prec_cap > digits_ext) ? prec_cap : digits_ext;

    // character at position emit_pos_reg, counted from the right
    assign cur_digit = bcd_reg[emit_pos_reg[DIGIT_IDX_W-1:0]*4 +: 4];
    always_comb
    begin
        if (emit_pos_reg < digits_ext)
            cur_char = CHAR_ZERO + {4'd0, cur_digit};
        else if (emit_pos_reg < body_reg)
            cur_char = CHAR_ZERO;
        else if (zero_fill_reg)
            cur_char = CHAR_ZERO;
        else
            cur_char = CHAR_SPACE;
    end

    assign load_ok = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next       = state_reg;
        value_next       = value_reg;
        bcd_next         = bcd_reg;
        step_next        = step_reg;
        digit_count_next = digit_count_reg;
        body_next        = body_reg;
        emit_pos_next    = emit_pos_reg;
        out_valid_next   = out_valid_reg;
        char_code_next   = char_code_reg;
        last_next        = last_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = value;
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next   = dabble_step(bcd_reg, value_reg[VALUE_W-1 -: STEP_BITS]);
                value_next = {value_reg[VALUE_W-STEP_BITS-1:0], {STEP_BITS{1'b0}}};
                step_next  = step_reg + STEP_CNT_W'(1);
                if (step_reg == STEP_CNT_W'(CONV_STEPS - 1))
                    state_next = ST_COUNT;
            end
            ST_COUNT:
            begin
                digit_count_next = digit_count_calc;
                state_next       = ST_SIZE;
            end
            ST_SIZE:
            begin
                body_next     = body_calc;
                // total is at least one digit, so total - 1 never wraps
                emit_pos_next = ((width_cap > body_calc) ? width_cap : body_calc)
                                - CNT_W'(1);
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    char_code_next = cur_char;
                    last_next      = (emit_pos_reg == '0);
                    emit_pos_next  = emit_pos_reg - CNT_W'(1);
                    if (emit_pos_reg == '0)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            value_reg       <= '0;
            bcd_reg         <= '0;
            step_reg        <= '0;
            digit_count_reg <= '0;
            body_reg        <= '0;
            emit_pos_reg    <= '0;
            out_valid_reg   <= 1'b0;
            char_code_reg   <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            value_reg       <= value_next;
            bcd_reg         <= bcd_next;
            step_reg        <= step_next;
            digit_count_reg <= digit_count_next;
            body_reg        <= body_next;
            emit_pos_reg    <= emit_pos_next;
            out_valid_reg   <= out_valid_next;
            char_code_reg   <= char_code_next;
            last_reg        <= last_next;
        end
    end

endmodule

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utpd_pkg::*;

    localparam int MAX_CHARS   = 32;
    localparam int DIGIT_SLOTS = DIGIT_DEPTH;
    // spare register index, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    // long receiver hold-off, enough to back the block up into its input
    localparam int HOLD_CYCLES = 300;
    // cycles with no handshake on any channel before the run is called hung
    localparam int QUIET_LIMIT = 4000;
    // settle time after the last character
    localparam int TAIL_CYCLES = 18 + MAX_CHARS + 10;

    typedef struct packed {
        logic [7:0] code;
        logic       is_last;
    } text_char_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [VALUE_W-1:0]    value     = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            char_code;
    logic                  last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // format registers as the block should currently hold them
    logic [5:0] fmt_field_width = '0;
    logic [5:0] fmt_min_digits  = '0;
    logic       fmt_zero_fill   = 1'b0;

    text_char_t pending_chars[$];
    text_char_t want_char;
    int         bad_chars    = 0;
    int         quiet_cycles = 0;

    // random gaps on both channels; cleared for one stretch of the run
    bit gaps_on      = 1'b1;
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;

    unsigned_to_padded_decimal #(
        .MAX_WIDTH(MAX_CHARS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Expected text of one number under the current format: digits split
    // least significant first, min_digits zeros next to them, fill in
    // front up to field_width, both sizes capped at MAX_CHARS.
    function automatic void predict_text(input logic [VALUE_W-1:0] num);
        logic [3:0]         digits [DIGIT_SLOTS];
        logic [VALUE_W-1:0] rest;
        int                 n_dig;
        int                 width_lim;
        int                 prec_lim;
        int                 body;
        int                 total;
        int                 n_fill;
        int                 n_zero;
        text_char_t         c;
        rest  = num;
        n_dig = 0;
        // zero still yields one digit
        do
        begin
            digits[n_dig] = 4'(rest % 64'd10);
            rest = rest / 64'd10;
            n_dig++;
        end while (rest != 0 && n_dig < DIGIT_SLOTS);
        width_lim = (fmt_field_width > MAX_CHARS) ? MAX_CHARS : int'(fmt_field_width);
        prec_lim  = (fmt_min_digits > MAX_CHARS) ? MAX_CHARS : int'(fmt_min_digits);
        body      = (prec_lim > n_dig) ? prec_lim : n_dig;
        total     = (width_lim > body) ? width_lim : body;
        if (total > MAX_CHARS)
            total = MAX_CHARS;
        n_fill = total - body;
        n_zero = body - n_dig;
        for (int k = 0; k < total; k++)
        begin
            if (k < n_fill)
                c.code = fmt_zero_fill ? CHAR_ZERO : CHAR_SPACE;
            else if (k < n_fill + n_zero)
                c.code = CHAR_ZERO;
            else
                c.code = CHAR_ZERO + 8'(digits[total - 1 - k]);
            c.is_last = (k == total - 1);
            pending_chars.push_back(c);
        end
    endfunction

    // Offer one number, holding it steady until the block takes it.
    task automatic send_value(input logic [VALUE_W-1:0] num);
        while (gaps_on && $urandom_range(99) < 9)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= num;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_text(num);
    endtask

    // Stop offering and let every expected character come out.
    task automatic drain_text;
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_FIELD_WIDTH: fmt_field_width = data;
            CFG_MIN_DIGITS:  fmt_min_digits  = data;
            CFG_ZERO_FILL:   fmt_zero_fill   = data[0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // New format, only once the block has gone quiet.
    task automatic set_format(input logic [5:0] fw, input logic [5:0] md,
                              input logic [5:0] zf);
        drain_text();
        write_reg(CFG_FIELD_WIDTH, fw);
        write_reg(CFG_MIN_DIGITS, md);
        write_reg(CFG_ZERO_FILL, zf);
    endtask

    // Reset format: bare digits, zero, single digits, decade edges, max.
    task automatic test_plain_digits;
        send_value(64'd0);
        send_value(64'd1);
        send_value(64'd9);
        send_value(64'd10);
        send_value(64'd9999999999999999999);
        send_value(64'd10000000000000000000);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // Leading zeros, including min_digits beyond the cap.
    task automatic test_min_digits;
        set_format(6'd0, 6'd5, 6'd0);
        send_value(64'd0);
        send_value(64'd123456);
        set_format(6'd0, 6'd32, 6'd0);
        send_value(64'd7);
        set_format(6'd0, 6'd63, 6'd0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
    endtask

    // Width fill with spaces and zeros, exact fit, both pads, cap.
    task automatic test_field_width;
        // upper data bits must not leak into the fill select
        set_format(6'd8, 6'd0, 6'h3E);
        send_value(64'd42);
        send_value(64'd12345678);
        set_format(6'd8, 6'd4, 6'h3F);
        send_value(64'd7);
        send_value(64'd0);
        set_format(6'd63, 6'd0, 6'd0);
        send_value(64'hFFFF_FFFF_FFFF_FFFF);
        set_format(6'd33, 6'd20, 6'd1);
        send_value(64'd5);
    endtask

    // A write to the spare index leaves the format alone.
    task automatic test_spare_index;
        set_format(6'd6, 6'd3, 6'd0);
        write_reg(CFG_SPARE, 6'h3F);
        send_value(64'd19);
        drain_text();
        write_reg(CFG_SPARE, 6'h00);
        send_value(64'd123);
    endtask

    // Receiver holds off while numbers keep coming, so the output
    // register fills and the block must stall its input.
    task automatic test_backpressure;
        set_format(6'd4, 6'd0, 6'd0);
        holds_asked++;
        for (int i = 0; i < 8; i++)
            send_value({$urandom, $urandom} >> $urandom_range(63));
    endtask

    function automatic logic [VALUE_W-1:0] random_value;
        logic [VALUE_W-1:0] p;
        case ($urandom_range(3))
            0: random_value = {$urandom, $urandom};
            1: random_value = {$urandom, $urandom} >> $urandom_range(63);
            2: random_value = 64'($urandom_range(999));
            default:
            begin
                // a power of ten or one below it
                p = 64'd1;
                repeat ($urandom_range(19))
                    p = p * 64'd10;
                random_value = p - 64'($urandom_range(1));
            end
        endcase
    endfunction

    // Several formats, extremes first and last, one phase without gaps.
    task automatic test_random_values;
        logic [5:0] fw;
        logic [5:0] md;
        for (int phase = 0; phase < 8; phase++)
        begin
            fw = 6'($urandom_range(63));
            md = 6'($urandom_range(63));
            if ($urandom_range(1))
            begin
                fw = 6'($urandom_range(24));
                md = 6'($urandom_range(22));
            end
            if (phase == 0)
            begin
                fw = 6'd0;
                md = 6'd0;
            end
            if (phase == 7)
            begin
                fw = 6'd63;
                md = 6'd63;
            end
            set_format(fw, md, 6'($urandom_range(63)));
            gaps_on = (phase != 3);
            for (int i = 0; i < 44; i++)
                send_value(random_value());
        end
        gaps_on = 1'b1;
    endtask

    // Receiver side: long hold-off when asked, random stalls otherwise.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (holds_served != holds_asked)
        begin
            holds_served = holds_asked;
            hold_left    = HOLD_CYCLES;
            out_stall   <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= gaps_on && ($urandom_range(99) < 9);
    end

    // Every character taken is matched against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                bad_chars++;
                if (bad_chars <= 10)
                    $display("%0t: unexpected char %h last %b", $realtime, char_code, last);
            end
            else
            begin
                want_char = pending_chars.pop_front();
                if (char_code !== want_char.code || last !== want_char.is_last)
                begin
                    bad_chars++;
                    if (bad_chars <= 10)
                        $display("%0t: char expected %h last %b, got %h last %b",
                                 $realtime, want_char.code, want_char.is_last,
                                 char_code, last);
                end
            end
        end
    end

    // Hang detection: no handshake on any channel for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_digits();
        test_min_digits();
        test_field_width();
        test_spare_index();
        test_backpressure();
        test_random_values();
        drain_text();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (bad_chars == 0 && pending_chars.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

>>> unsigned_to_padded_decimal.f
design/utpd_pkg.sv
design/unsigned_to_padded_decimal.sv
bench/tb.sv
